@@ src/scalar_kalman_filter_defines.svh @@
// Assertion macros for the checker file of the scalar Kalman filter.
`ifndef SCALAR_KALMAN_FILTER_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SKF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SKF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/skf_pkg.sv @@
`default_nettype none

package skf_pkg;

   localparam int DATA_W    = 32;
   localparam int GAIN_BITS = 16;
   localparam int GAIN_W    = GAIN_BITS + 1;

   // The quotient p / (p + r) never exceeds one, so the divider needs one
   // integer step plus one step per fraction bit.
   localparam int DIV_STEPS = GAIN_BITS + 1;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_EST   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROC_NOISE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAS_NOISE = 2'd2;

   localparam logic [DATA_W-1:0] INIT_EST_RST   = 32'd0;
   localparam logic [DATA_W-1:0] PROC_NOISE_RST = 32'd65;
   localparam logic [DATA_W-1:0] MEAS_NOISE_RST = 32'd65536;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the measurement and the noisy covariance
      logic prep;       // form the divisor and the innovation
      logic div_step;   // one restoring divide iteration
      logic div_first;  // integer step of the divide, no shift
      logic mul_en;     // use the shared multiplier
      logic mul_sel_p;  // multiply gain by covariance instead of innovation
      logic commit;     // update state and load the output register
   } skf_cmd_type;

endpackage

`default_nettype wire

@@ src/skf_ctrl.sv @@
`default_nettype none

module skf_ctrl import skf_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      skf_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL_E,
      ST_MUL_P,
      ST_COMMIT
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             req_stall_ff;
   logic             rsp_valid_ff;
   logic             out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         req_stall_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A commit refills the output register in the cycle it drains.
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !req_stall_ff) begin
                  state_ff     <= ST_PREP;
                  req_stall_ff <= 1'b1;
               end else begin
                  req_stall_ff <= 1'b0;
               end
            end
            ST_PREP: begin
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + CNT_W'(1);
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  state_ff <= ST_MUL_E;
               end
            end
            ST_MUL_E: begin
               state_ff <= ST_MUL_P;
            end
            ST_MUL_P: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (out_free) begin
                  req_stall_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_comb begin
      cmd           = '0;
      cmd.load      = (state_ff == ST_IDLE) && req_valid && !req_stall_ff;
      cmd.prep      = (state_ff == ST_PREP);
      cmd.div_step  = (state_ff == ST_DIV);
      cmd.div_first = (cnt_ff == '0);
      cmd.mul_en    = (state_ff == ST_MUL_E) || (state_ff == ST_MUL_P);
      cmd.mul_sel_p = (state_ff == ST_MUL_P);
      cmd.commit    = (state_ff == ST_COMMIT) && out_free;
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ src/skf_dp.sv @@
`default_nettype none

module skf_dp import skf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire skf_cmd_type                 cmd,
   input  wire logic signed [DATA_W-1:0]    req_measurement,
   input  wire logic                        csr_write_enable,
   input  wire logic        [CSR_IDX_W-1:0] csr_index,
   input  wire logic        [DATA_W-1:0]    csr_write_data,
   output      logic signed [DATA_W-1:0]    rsp_estimate,
   output      logic        [DATA_W-1:0]    rsp_error_covariance,
   output      logic        [GAIN_W-1:0]    rsp_gain
);

   localparam logic [DATA_W-1:0] COV_ONE = DATA_W'(1) << FRAC_BITS;
   localparam int MUL_A_W = GAIN_W + 1;
   localparam int MUL_B_W = DATA_W + 2;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int PE_W    = DATA_W + GAIN_W + 1;
   localparam int PP_W    = DATA_W + GAIN_BITS;

   // Configuration and filter state.
   logic        [DATA_W-1:0] init_est_ff;
   logic        [DATA_W-1:0] proc_noise_ff;
   logic        [DATA_W-1:0] meas_noise_ff;
   logic signed [DATA_W-1:0] estimate_ff;
   logic        [DATA_W-1:0] covar_ff;

   // Working registers of one transaction.
   logic signed [DATA_W-1:0]  meas_ff;
   logic        [DATA_W-1:0]  p_ff;
   logic        [DATA_W:0]    den_ff;
   logic                      den_zero_ff;
   logic        [DATA_W+1:0]  rem_ff;
   logic        [GAIN_W-1:0]  quot_ff;
   logic signed [DATA_W:0]    diff_ff;
   logic signed [PE_W-1:0]    prod_e_ff;
   logic        [PP_W-1:0]    prod_p_ff;

   // Output register.
   logic signed [DATA_W-1:0] rsp_estimate_ff;
   logic        [DATA_W-1:0] rsp_covar_ff;
   logic        [GAIN_W-1:0] rsp_gain_ff;

   logic        [DATA_W:0]    p_sum;
   logic        [DATA_W-1:0]  p_sat;
   logic        [DATA_W+1:0]  rem_shift;
   logic        [DATA_W+1:0]  den_ext;
   logic                      div_ge;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_out;
   logic signed [DATA_W+2:0]  nx;
   logic signed [DATA_W-1:0]  nx_clamp;
   logic        [DATA_W-1:0]  covar_new;

   assign p_sum = {1'b0, covar_ff} + {1'b0, proc_noise_ff};
   assign p_sat = p_sum[DATA_W] ? '1 : p_sum[DATA_W-1:0];

   assign den_ext   = {1'b0, den_ff};
   assign rem_shift = cmd.div_first ? rem_ff : {rem_ff[DATA_W:0], 1'b0};
   assign div_ge    = !den_zero_ff && (rem_shift >= den_ext);

   assign mul_a   = {1'b0, quot_ff};
   assign mul_b   = cmd.mul_sel_p ? {2'b00, p_ff} : {diff_ff[DATA_W], diff_ff};
   assign mul_out = mul_a * mul_b;

   // Floor shift of the correction, then add to the old estimate.
   assign nx = {{3{estimate_ff[DATA_W-1]}}, estimate_ff}
             + {prod_e_ff[PE_W-1], prod_e_ff[PE_W-1:GAIN_BITS]};

   always_comb begin
      if (nx[DATA_W+2:DATA_W-1] == '0 || nx[DATA_W+2:DATA_W-1] == '1) begin
         nx_clamp = nx[DATA_W-1:0];
      end else if (nx[DATA_W+2]) begin
         nx_clamp = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         nx_clamp = {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   assign covar_new = p_ff - prod_p_ff[PP_W-1:GAIN_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         init_est_ff   <= INIT_EST_RST;
         proc_noise_ff <= PROC_NOISE_RST;
         meas_noise_ff <= MEAS_NOISE_RST;
         estimate_ff   <= INIT_EST_RST;
         covar_ff      <= COV_ONE;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INIT_EST: begin
               init_est_ff <= csr_write_data;
               estimate_ff <= csr_write_data;
               covar_ff    <= COV_ONE;
            end
            CSR_PROC_NOISE: begin
               proc_noise_ff <= csr_write_data;
               estimate_ff   <= init_est_ff;
               covar_ff      <= COV_ONE;
            end
            CSR_MEAS_NOISE: begin
               meas_noise_ff <= csr_write_data;
               estimate_ff   <= init_est_ff;
               covar_ff      <= COV_ONE;
            end
            default: begin
            end
         endcase
      end else if (cmd.commit) begin
         estimate_ff <= nx_clamp;
         covar_ff    <= covar_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         meas_ff <= req_measurement;
         p_ff    <= p_sat;
      end
      if (cmd.prep) begin
         den_ff      <= {1'b0, p_ff} + {1'b0, meas_noise_ff};
         den_zero_ff <= (p_ff == '0) && (meas_noise_ff == '0);
         rem_ff      <= {2'b00, p_ff};
         quot_ff     <= '0;
         diff_ff     <= {meas_ff[DATA_W-1], meas_ff} - {estimate_ff[DATA_W-1], estimate_ff};
      end
      if (cmd.div_step) begin
         rem_ff  <= div_ge ? rem_shift - den_ext : rem_shift;
         quot_ff <= {quot_ff[GAIN_W-2:0], div_ge};
      end
      if (cmd.mul_en) begin
         if (cmd.mul_sel_p) begin
            prod_p_ff <= mul_out[PP_W-1:0];
         end else begin
            prod_e_ff <= mul_out[PE_W-1:0];
         end
      end
      if (cmd.commit) begin
         rsp_estimate_ff <= nx_clamp;
         rsp_covar_ff    <= covar_new;
         rsp_gain_ff     <= quot_ff;
      end
   end

   assign rsp_estimate         = rsp_estimate_ff;
   assign rsp_error_covariance = rsp_covar_ff;
   assign rsp_gain             = rsp_gain_ff;

endmodule

`default_nettype wire

@@ src/scalar_kalman_filter.sv @@
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_measurement (signed Q16.16)
// rsp_      out        rsp_valid/rsp_stall   rsp_estimate, rsp_error_covariance,
//                                            rsp_gain (Q1.16)
// csr_      in         csr_write_enable      csr_index, csr_write_data
//
// A result reaches the output register after its transaction is accepted
// through a setup state, 17 iterations of the restoring divider that forms
// the gain, the innovation and covariance products on the shared multiplier
// and a commit state that waits while the output register is still full. The
// controller is back in idle after the commit; only then is a new one taken.
// Reset is synchronous and active high; it loads the default registers, the
// initial estimate and a covariance of 1.0, and holds req_stall high.
// A new transaction is taken while a finished result still waits on rsp_stall;
// only the commit of that second result waits for the output register.
`default_nettype none

module scalar_kalman_filter import skf_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire logic signed [DATA_W-1:0]    req_measurement,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic signed [DATA_W-1:0]    rsp_estimate,
   output      logic        [DATA_W-1:0]    rsp_error_covariance,
   output      logic        [GAIN_W-1:0]    rsp_gain,
   input  wire logic                        csr_write_enable,
   input  wire logic        [CSR_IDX_W-1:0] csr_index,
   input  wire logic        [DATA_W-1:0]    csr_write_data
);

   // The controller sequences one transaction at a time and owns both
   // handshakes; the datapath holds the configuration, the filter state,
   // the divider, the multiplier and the output payload register.
   skf_cmd_type cmd;

   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Configuration writes reload the estimate and the covariance directly in
   // the datapath; writes to an index beyond the register list are ignored.
   skf_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_measurement      (req_measurement),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_estimate         (rsp_estimate),
      .rsp_error_covariance (rsp_error_covariance),
      .rsp_gain             (rsp_gain)
   );

endmodule

`default_nettype wire

@@ src/skf_checker.sv @@
`default_nettype none

`include "scalar_kalman_filter_defines.svh"

module skf_checker import skf_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic signed [DATA_W-1:0] rsp_estimate,
   input wire logic        [GAIN_W-1:0] rsp_gain
);

   // A held result keeps its estimate and gain until it is taken.
   `SKF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_estimate) && $stable(rsp_gain), "result changed while stalled")

   // The block works on one transaction at a time.
   `SKF_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "second transaction accepted while busy")

   // A new result only appears at the end of a transaction in progress.
   `SKF_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall), "result without a transaction")

   // The gain never exceeds one.
   `SKF_ASSERT_NOW(a_gain_range, clock, reset, rsp_valid, rsp_gain <= GAIN_ONE, "gain above one")

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_estimate (rsp_estimate),
   .rsp_gain     (rsp_gain)
);

`default_nettype wire

@@ sim/tb_scalar_kalman_filter.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the scalar Kalman filter. A behavioral copy of the
// filter runs beside the design. Every accepted measurement transaction is
// pushed through that copy, and the expected update waits in a queue until the
// design hands back its result transaction.
module tb_scalar_kalman_filter;
   import skf_pkg::*;

   localparam int TARGET_ITEMS   = 1700;
   // Each transaction, with the longest random stall, ends well inside this
   // limit, so running into it can only mean that the design is hung.
   localparam int WATCHDOG_LIMIT = 4000;
   // Cycles allowed after the last result before config writes or the end.
   localparam int SETTLE_CYCLES  = 30;

   // Index 3 decodes to no register. Writing it must not reload the state.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam logic [DATA_W-1:0] COV_ONE       = 32'h0001_0000;
   localparam logic [DATA_W-1:0] ALL_ONES      = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] MOST_NEGATIVE = 32'h8000_0000;

   typedef struct packed {
      logic signed [DATA_W-1:0] estimate;
      logic        [DATA_W-1:0] covariance;
      logic        [GAIN_W-1:0] gain;
   } filter_update_type;

   // Every input is driven to a known value from time zero.
   logic                        clock;
   logic                        reset            = 1'b1;
   logic                        req_valid        = 1'b0;
   logic                        req_stall;
   logic signed [DATA_W-1:0]    req_measurement  = '0;
   logic                        rsp_valid;
   logic                        rsp_stall        = 1'b0;
   logic signed [DATA_W-1:0]    rsp_estimate;
   logic        [DATA_W-1:0]    rsp_error_covariance;
   logic        [GAIN_W-1:0]    rsp_gain;
   logic                        csr_write_enable = 1'b0;
   logic        [CSR_IDX_W-1:0] csr_index        = '0;
   logic        [DATA_W-1:0]    csr_write_data   = '0;

   // The bench's own copy of the filter registers, starting at reset values.
   logic signed [DATA_W-1:0] cfg_initial_estimate  = INIT_EST_RST;
   logic        [DATA_W-1:0] cfg_process_noise     = PROC_NOISE_RST;
   logic        [DATA_W-1:0] cfg_measurement_noise = MEAS_NOISE_RST;
   logic signed [DATA_W-1:0] model_estimate        = INIT_EST_RST;
   logic        [DATA_W-1:0] model_covariance      = COV_ONE;

   filter_update_type pending_updates[$];

   int errors          = 0;
   int items_accepted  = 0;
   int results_checked = 0;
   int csr_writes      = 0;
   int quiet_cycles    = 0;
   // Percent chance of a gap on the request side and a stall on the response side.
   int idle_pct        = 15;
   int stall_pct       = 15;

   scalar_kalman_filter dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_measurement      (req_measurement),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_estimate         (rsp_estimate),
      .rsp_error_covariance (rsp_error_covariance),
      .rsp_gain             (rsp_gain),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // A register write stores the value and then restarts the filter from the
   // initial estimate with a covariance of one. An unmapped index does nothing.
   function automatic void apply_csr_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [DATA_W-1:0] value);
      case (idx)
         CSR_INIT_EST:   cfg_initial_estimate  = value;
         CSR_PROC_NOISE: cfg_process_noise     = value;
         CSR_MEAS_NOISE: cfg_measurement_noise = value;
         default:        return;
      endcase
      model_estimate   = cfg_initial_estimate;
      model_covariance = COV_ONE;
   endfunction

   // One filter step. All the arithmetic is done in 64 bits so that nothing
   // wraps before the final truncation. The prior covariance saturates at all
   // ones. The gain is a Q1.16 quotient, and it is zero when p + r is zero.
   // The innovation product is floored by an arithmetic shift.
   function automatic filter_update_type advance_filter(
      input logic signed [DATA_W-1:0] meas);
      logic [63:0]       p_prior;
      logic [63:0]       denom;
      logic [63:0]       k;
      longint            x_old;
      longint            x_new;
      filter_update_type upd;
      p_prior = 64'(model_covariance) + 64'(cfg_process_noise);
      if (p_prior > 64'(ALL_ONES)) begin
         p_prior = 64'(ALL_ONES);
      end
      denom = p_prior + 64'(cfg_measurement_noise);
      k = (denom == 64'd0) ? 64'd0 : (p_prior << GAIN_BITS) / denom;
      x_old = longint'(model_estimate);
      x_new = x_old + ((longint'(k) * (longint'(meas) - x_old)) >>> GAIN_BITS);
      // The update stays between the old estimate and the measurement, so
      // this clamp only guards against surprises.
      if (x_new > longint'(MOST_POSITIVE)) begin
         x_new = longint'(MOST_POSITIVE);
      end
      if (x_new < longint'(signed'(MOST_NEGATIVE))) begin
         x_new = longint'(signed'(MOST_NEGATIVE));
      end
      p_prior = p_prior - ((k * p_prior) >> GAIN_BITS);
      model_estimate   = x_new[DATA_W-1:0];
      model_covariance = p_prior[DATA_W-1:0];
      upd.estimate   = model_estimate;
      upd.covariance = model_covariance;
      upd.gain       = k[GAIN_W-1:0];
      return upd;
   endfunction

   // Predict at the edge where the design accepts a measurement transaction.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_updates.push_back(advance_filter(req_measurement));
         items_accepted++;
      end
   end

   // Compare each accepted result transaction with the oldest prediction.
   always @(posedge clock) begin
      filter_update_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (pending_updates.size() == 0) begin
            $display("%0t: result with nothing expected, estimate %h covariance %h gain %h",
                     $time, rsp_estimate, rsp_error_covariance, rsp_gain);
            errors++;
         end else begin
            want = pending_updates.pop_front();
            if (rsp_estimate !== want.estimate) begin
               $display("%0t: estimate mismatch, expected %h, actual %h",
                        $time, want.estimate, rsp_estimate);
               errors++;
            end
            if (rsp_error_covariance !== want.covariance) begin
               $display("%0t: covariance mismatch, expected %h, actual %h",
                        $time, want.covariance, rsp_error_covariance);
               errors++;
            end
            if (rsp_gain !== want.gain) begin
               $display("%0t: gain mismatch, expected %h, actual %h",
                        $time, want.gain, rsp_gain);
               errors++;
            end
         end
      end
   end

   // The response side stalls at random. The stall is drawn on every falling
   // edge, whether or not a result is waiting, so that it lands on all phases.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // The watchdog restarts whenever either channel completes a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d predictions outstanding",
                     $time, quiet_cycles, pending_updates.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Offers one measurement, after an optional random gap, and returns at the
   // edge where it is taken. Valid stays high on return, so that a following
   // call can present its value on the next falling edge with no extra bubble.
   task automatic send_measurement(input logic signed [DATA_W-1:0] value);
      @(negedge clock);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid       <= 1'b0;
         req_measurement <= $urandom();
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_measurement <= value;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   // Drops valid and waits until every prediction has been matched. Then it
   // waits SETTLE_CYCLES more rising edges before it returns.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_updates.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes one register. The write enable is high for a single rising edge.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      apply_csr_write(idx, value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      csr_writes++;
   endtask

   // Measurement extremes with the reset configuration: q = 65, r = 1.0.
   task automatic test_reset_defaults();
      send_measurement('0);
      send_measurement(MOST_POSITIVE);
      send_measurement(MOST_NEGATIVE);
      send_measurement(ALL_ONES);
      send_measurement(COV_ONE);
   endtask

   // Writes every register with extreme values and checks the reload. With
   // r = 0 the gain is exactly one, so the estimate jumps across the whole
   // signed range. Then an unmapped write must leave the state untouched.
   task automatic test_register_writes();
      wait_until_idle();
      write_register(CSR_MEAS_NOISE, '0);
      write_register(CSR_INIT_EST, MOST_NEGATIVE);
      send_measurement(MOST_POSITIVE);
      wait_until_idle();
      write_register(CSR_PROC_NOISE, ALL_ONES);
      write_register(CSR_MEAS_NOISE, ALL_ONES);
      write_register(CSR_INIT_EST, MOST_POSITIVE);
      send_measurement(MOST_NEGATIVE);
      send_measurement('0);
      wait_until_idle();
      write_register(CSR_UNMAPPED, ALL_ONES);
      send_measurement(32'sh0000_1234);
      send_measurement(-32'sh0010_0000);
   endtask

   // With q = r = 0 the first step has a gain of one and leaves p at zero.
   // After that p + r is zero, so the gain is zero and the state holds still.
   task automatic test_zero_denominator();
      wait_until_idle();
      write_register(CSR_PROC_NOISE, '0);
      write_register(CSR_MEAS_NOISE, '0);
      write_register(CSR_INIT_EST, 32'h0001_2345);
      send_measurement(32'sh7654_3210);
      send_measurement(MOST_NEGATIVE);
      send_measurement(32'sh0000_0001);
   endtask

   // A process noise of all ones saturates the prior covariance on every step.
   task automatic test_covariance_saturation();
      wait_until_idle();
      write_register(CSR_PROC_NOISE, ALL_ONES);
      write_register(CSR_MEAS_NOISE, 32'h0000_0001);
      send_measurement(32'sh0100_0000);
      send_measurement(-32'sh0100_0000);
      send_measurement(MOST_POSITIVE);
   endtask

   // Random phases. Each phase draws a configuration and then tracks a drifting
   // signal through noisy samples, with occasional full-range outliers. One
   // phase runs long with neither gaps nor stalls.
   task automatic test_random_phases();
      int                       phase;
      int                       count;
      int                       amp;
      logic signed [DATA_W-1:0] truth;
      logic signed [DATA_W-1:0] sample;
      phase = 0;
      while (items_accepted < TARGET_ITEMS) begin
         wait_until_idle();
         case ($urandom_range(3))
            0: begin
               write_register(CSR_PROC_NOISE, $urandom_range(0, 4096));
               write_register(CSR_MEAS_NOISE, $urandom_range(1, 1 << 20));
            end
            1: begin
               write_register(CSR_PROC_NOISE, $urandom());
               write_register(CSR_MEAS_NOISE, $urandom());
            end
            2: begin
               write_register(CSR_PROC_NOISE, ($urandom_range(1)) ? ALL_ONES : '0);
               write_register(CSR_MEAS_NOISE, ($urandom_range(1)) ? ALL_ONES : '0);
            end
            default: ;
         endcase
         if ($urandom_range(4) == 0) begin
            write_register(CSR_UNMAPPED, $urandom());
         end
         truth = $urandom();
         write_register(CSR_INIT_EST, ($urandom_range(7) == 0) ? truth : $urandom());
         if (phase == 3) begin
            idle_pct  = 0;
            stall_pct = 0;
            count     = 300;
         end else begin
            idle_pct  = 15;
            stall_pct = 15;
            count     = $urandom_range(60, 160);
         end
         amp = 1 << $urandom_range(4, 24);
         for (int i = 0; i < count; i++) begin
            if ($urandom_range(9) < 8) begin
               truth  = truth + (int'($urandom_range(0, amp / 8)) - amp / 16);
               sample = truth + (int'($urandom_range(0, 2 * amp)) - amp);
            end else begin
               sample = $urandom();
            end
            send_measurement(sample);
         end
         phase++;
      end
      idle_pct  = 15;
      stall_pct = 15;
   endtask

   initial begin
      // Synchronous reset is held high, then released on a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_register_writes();
      test_zero_denominator();
      test_covariance_saturation();
      test_random_phases();
      wait_until_idle();

      $display("Sent %0d measurements and checked %0d updates across %0d register writes.",
               items_accepted, results_checked, csr_writes);
      $display("Noise settings ran from zero to all ones, with and without handshake gaps.");
      if (errors == 0 && pending_updates.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
